// ----- rtl/pmq_pkg.sv -----
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared constants, codes and types of the pooled message queue.
// ----------------------------------------------------------------------------
package pmq_pkg;

  localparam int DEPTH     = 16;
  localparam int TYPE_BITS = 8;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int PTR_W = IDX_W + 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int HANDLE_W = 32;
  localparam int LENGTH_W = 11;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(DEPTH);

  localparam logic [2:0] OP_SEND     = 3'd0;
  localparam logic [2:0] OP_SEND_UNQ = 3'd1;
  localparam logic [2:0] OP_RECV     = 3'd2;
  localparam logic [2:0] OP_PEEK     = 3'd3;
  localparam logic [2:0] OP_RELEASE  = 3'd4;
  localparam logic [2:0] OP_PURGE    = 3'd5;
  localparam logic [2:0] OP_FREE_ALL = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_DUP   = 2'd3;

  typedef struct packed {
    logic [TYPE_BITS-1:0] mtype;
    logic [HANDLE_W-1:0]  handle;
    logic [LENGTH_W-1:0]  length;
    logic                 safe;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [PTR_W-1:0] data;
  } link_wr_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } pay_wr_t;

endpackage

// ----- rtl/pmq_store.sv -----
// ----------------------------------------------------------------------------
// pmq_store
// Entry pool memories: the link memory with its reset chain and the payload
// memory, one write port each and a shared registered read address.
// ----------------------------------------------------------------------------
module pmq_store import pmq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  link_wr_t         link_wr,
  input  pay_wr_t          pay_wr,
  input  logic [IDX_W-1:0] raddr,
  output logic [PTR_W-1:0] link_rdata,
  output entry_t           pay_rdata
);

  logic [PTR_W-1:0] link_mem [DEPTH];
  entry_t           pay_mem  [DEPTH];
  logic [DEPTH-1:0] link_vld_r;

  logic [PTR_W-1:0] link_rd_r;
  logic             vld_rd_r;
  logic [IDX_W-1:0] rd_addr_r;
  entry_t           pay_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
    end else if (link_wr.we) begin
      link_vld_r[link_wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (link_wr.we) begin
      link_mem[link_wr.addr] <= link_wr.data;
    end
    if (pay_wr.we) begin
      pay_mem[pay_wr.addr] <= pay_wr.data;
    end
    link_rd_r <= link_mem[raddr];
    vld_rd_r  <= link_vld_r[raddr];
    rd_addr_r <= raddr;
    pay_rd_r  <= pay_mem[raddr];
  end

  // An entry never written since reset still links to its successor; the
  // last entry's successor is the null code.
  assign link_rdata = vld_rd_r ? link_rd_r : ({1'b0, rd_addr_r} + PTR_W'(1));
  assign pay_rdata  = pay_rd_r;

endmodule

// ----- rtl/pooled_message_queue.sv -----
// ----------------------------------------------------------------------------
// pooled_message_queue
// Message queue over a fixed pool of entries with a free list and a FIFO
// send list, run by a sequencer over the link and payload memories.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; exactly one
// result word follows, shown for one cycle with out_valid, and the receiver
// cannot stall it. Each list step is one memory read, and the result word
// shows in the cycle after the last step. Release, unused codes, a send to a
// full pool and a receive or peek on an empty queue are answered without a
// list step; receive and peek read the head, a send reads the free head and
// links the word behind pending words through the tail, send unique first
// checks each pending word in turn and drops a duplicate at the matching
// word, purge visits each pending word and relinks the predecessor of each
// unlinked word, and release all visits each pending word. busy is high
// while the sequencer is away from idle and falls as the result word shows.
module pooled_message_queue import pmq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_msg_type,
  input  logic [31:0] in_data_handle,
  input  logic [10:0] in_length,
  input  logic        in_safe_flag,
  input  logic [3:0]  in_entry_index,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [3:0]  out_index,
  output logic [7:0]  out_type,
  output logic [31:0] out_handle,
  output logic [10:0] out_length,
  output logic        out_safe,
  output logic [4:0]  out_pending_count,
  output logic        out_priority_notify
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC,
    S_TAIL,
    S_UNIQ,
    S_RECV,
    S_PURGE,
    S_PURGE_FIX,
    S_FREE_ALL
  } state_t;

  state_t               state_r, state_nxt;
  logic [PTR_W-1:0]     free_head_r, free_head_nxt;
  logic [PTR_W-1:0]     send_head_r, send_head_nxt;
  logic [PTR_W-1:0]     send_tail_r, send_tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [DEPTH-1:0]     held_r, held_nxt;
  logic                 notify_en_r;
  logic [2:0]           op_r, op_nxt;
  entry_t               item_r, item_nxt;
  logic [PTR_W-1:0]     cur_r, cur_nxt;
  logic [PTR_W-1:0]     prev_r, prev_nxt;
  logic [PTR_W-1:0]     next_r, next_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [3:0]           oidx_r, oidx_nxt;
  logic [7:0]           otype_r, otype_nxt;
  logic [31:0]          ohandle_r, ohandle_nxt;
  logic [10:0]          olen_r, olen_nxt;
  logic                 osafe_r, osafe_nxt;
  logic                 notify_r, notify_nxt;

  link_wr_t             link_wr;
  pay_wr_t              pay_wr;
  logic [PTR_W-1:0]     link_rdata;
  entry_t               pay_rdata;

  pmq_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .link_wr    (link_wr),
    .pay_wr     (pay_wr),
    .raddr      (cur_nxt[IDX_W-1:0]),
    .link_rdata (link_rdata),
    .pay_rdata  (pay_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    free_head_nxt = free_head_r;
    send_head_nxt = send_head_r;
    send_tail_nxt = send_tail_r;
    count_nxt     = count_r;
    held_nxt      = held_r;
    op_nxt        = op_r;
    item_nxt      = item_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    next_nxt      = next_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    oidx_nxt      = oidx_r;
    otype_nxt     = otype_r;
    ohandle_nxt   = ohandle_r;
    olen_nxt      = olen_r;
    osafe_nxt     = osafe_r;
    notify_nxt    = notify_r;
    link_wr       = '0;
    pay_wr        = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt          = in_op;
          item_nxt.mtype  = in_msg_type[TYPE_BITS-1:0];
          item_nxt.handle = in_data_handle;
          item_nxt.length = in_length;
          item_nxt.safe   = in_safe_flag;
          // Result fields an operation does not report stay zero.
          status_nxt  = ST_OK;
          oidx_nxt    = '0;
          otype_nxt   = '0;
          ohandle_nxt = '0;
          olen_nxt    = '0;
          osafe_nxt   = 1'b0;
          notify_nxt  = 1'b0;
          case (in_op)
            OP_SEND: begin
              if (free_head_r == NIL) begin
                status_nxt    = ST_FULL;
                out_valid_nxt = 1'b1;
              end else begin
                cur_nxt   = free_head_r;
                state_nxt = S_ALLOC;
              end
            end
            OP_SEND_UNQ: begin
              if (send_head_r == NIL) begin
                state_nxt = S_ALLOC_RD;
              end else begin
                cur_nxt   = send_head_r;
                state_nxt = S_UNIQ;
              end
            end
            OP_RECV, OP_PEEK: begin
              if (send_head_r == NIL) begin
                status_nxt    = ST_EMPTY;
                out_valid_nxt = 1'b1;
              end else begin
                cur_nxt   = send_head_r;
                state_nxt = S_RECV;
              end
            end
            OP_RELEASE: begin
              if ((32'(in_entry_index) < 32'(DEPTH)) &&
                  held_r[in_entry_index[IDX_W-1:0]]) begin
                held_nxt[in_entry_index[IDX_W-1:0]] = 1'b0;
                link_wr.we   = 1'b1;
                link_wr.addr = in_entry_index[IDX_W-1:0];
                link_wr.data = free_head_r;
                free_head_nxt = {1'b0, in_entry_index[IDX_W-1:0]};
              end else begin
                status_nxt = ST_EMPTY;
              end
              out_valid_nxt = 1'b1;
            end
            OP_PURGE: begin
              if (send_head_r == NIL) begin
                out_valid_nxt = 1'b1;
              end else begin
                cur_nxt   = send_head_r;
                prev_nxt  = NIL;
                state_nxt = S_PURGE;
              end
            end
            OP_FREE_ALL: begin
              if (send_head_r == NIL) begin
                out_valid_nxt = 1'b1;
              end else begin
                cur_nxt   = send_head_r;
                state_nxt = S_FREE_ALL;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_ALLOC_RD: begin
        if (free_head_r == NIL) begin
          status_nxt    = ST_FULL;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cur_nxt   = free_head_r;
          state_nxt = S_ALLOC;
        end
      end

      // The link word of the allocated entry is the new free head.
      S_ALLOC: begin
        free_head_nxt = link_rdata;
        pay_wr.we     = 1'b1;
        pay_wr.addr   = cur_r[IDX_W-1:0];
        pay_wr.data   = item_r;
        link_wr.we    = 1'b1;
        link_wr.addr  = cur_r[IDX_W-1:0];
        link_wr.data  = NIL;
        oidx_nxt      = 4'(cur_r[IDX_W-1:0]);
        notify_nxt    = notify_en_r;
        if (send_tail_r != NIL) begin
          state_nxt = S_TAIL;
        end else begin
          send_head_nxt = cur_r;
          send_tail_nxt = cur_r;
          count_nxt     = count_r + CNT_W'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_TAIL: begin
        link_wr.we    = 1'b1;
        link_wr.addr  = send_tail_r[IDX_W-1:0];
        link_wr.data  = cur_r;
        send_tail_nxt = cur_r;
        count_nxt     = count_r + CNT_W'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_UNIQ: begin
        if (pay_rdata.mtype == item_r.mtype) begin
          status_nxt    = ST_DUP;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (link_rdata == NIL) begin
          state_nxt = S_ALLOC_RD;
        end else begin
          cur_nxt = link_rdata;
        end
      end

      S_RECV: begin
        oidx_nxt    = 4'(cur_r[IDX_W-1:0]);
        otype_nxt   = 8'(pay_rdata.mtype);
        ohandle_nxt = pay_rdata.handle;
        olen_nxt    = pay_rdata.length;
        osafe_nxt   = pay_rdata.safe;
        if (op_r == OP_RECV) begin
          send_head_nxt = link_rdata;
          if (link_rdata == NIL) begin
            send_tail_nxt = NIL;
          end
          link_wr.we   = 1'b1;
          link_wr.addr = cur_r[IDX_W-1:0];
          link_wr.data = NIL;
          held_nxt[cur_r[IDX_W-1:0]] = 1'b1;
          if (count_r != '0) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      // A matching entry is pushed on the free list now; relinking its
      // predecessor takes the following cycle.
      S_PURGE: begin
        if (pay_rdata.mtype == item_r.mtype) begin
          link_wr.we    = 1'b1;
          link_wr.addr  = cur_r[IDX_W-1:0];
          link_wr.data  = free_head_r;
          free_head_nxt = cur_r;
          if (cur_r == send_tail_r) begin
            send_tail_nxt = prev_r;
          end
          if (cur_r == send_head_r) begin
            send_head_nxt = link_rdata;
          end
          if (count_r != '0) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end else begin
          prev_nxt = cur_r;
        end
        if ((pay_rdata.mtype == item_r.mtype) && (prev_r != NIL)) begin
          next_nxt  = link_rdata;
          state_nxt = S_PURGE_FIX;
        end else if (link_rdata == NIL) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cur_nxt = link_rdata;
        end
      end

      S_PURGE_FIX: begin
        link_wr.we   = 1'b1;
        link_wr.addr = prev_r[IDX_W-1:0];
        link_wr.data = next_r;
        if (next_r == NIL) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cur_nxt   = next_r;
          state_nxt = S_PURGE;
        end
      end

      S_FREE_ALL: begin
        link_wr.we    = 1'b1;
        link_wr.addr  = cur_r[IDX_W-1:0];
        link_wr.data  = free_head_r;
        free_head_nxt = cur_r;
        if (link_rdata == NIL) begin
          send_head_nxt = NIL;
          send_tail_nxt = NIL;
          count_nxt     = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cur_nxt = link_rdata;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      send_head_r <= NIL;
      send_tail_r <= NIL;
      count_r     <= '0;
      held_r      <= '0;
      notify_en_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      send_head_r <= send_head_nxt;
      send_tail_r <= send_tail_nxt;
      count_r     <= count_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        notify_en_r <= cfg_wdata;
      end
    end
    op_r      <= op_nxt;
    item_r    <= item_nxt;
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    next_r    <= next_nxt;
    status_r  <= status_nxt;
    oidx_r    <= oidx_nxt;
    otype_r   <= otype_nxt;
    ohandle_r <= ohandle_nxt;
    olen_r    <= olen_nxt;
    osafe_r   <= osafe_nxt;
    notify_r  <= notify_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_index           = oidx_r;
  assign out_type            = otype_r;
  assign out_handle          = ohandle_r;
  assign out_length          = olen_r;
  assign out_safe            = osafe_r;
  assign out_pending_count   = 5'(count_r);
  assign out_priority_notify = notify_r;

endmodule

// ----- sim/pooled_message_queue_tb.sv -----
// ----------------------------------------------------------------------------
// pooled_message_queue_tb
// Self-checking bench for the pooled message queue. A driver replays a list
// of command words and register writes, a monitor predicts every result from
// its own model of the free list and the send list and compares each field.
// ----------------------------------------------------------------------------
module pooled_message_queue_tb;
  import pmq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED  = 3'd7;
  localparam int      SETTLE_CYCLES = 4;
  localparam int      TAIL_CYCLES   = 40;
  localparam int      LIMIT_CYCLES  = 400000;
  localparam int      RANDOM_WORDS  = 1050;

  typedef enum logic [1:0] {ACT_WORD, ACT_CFG, ACT_DRAIN} act_t;

  typedef struct packed {
    act_t                 act;
    logic [2:0]           op;
    logic [TYPE_BITS-1:0] mtype;
    logic [HANDLE_W-1:0]  handle;
    logic [LENGTH_W-1:0]  len;
    logic                 safe;
    logic [IDX_W-1:0]     eidx;
    logic                 pick_held;
    logic                 cfg_val;
    logic [3:0]           gap;
  } stim_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [IDX_W-1:0]     index;
    logic [TYPE_BITS-1:0] mtype;
    logic [HANDLE_W-1:0]  handle;
    logic [LENGTH_W-1:0]  len;
    logic                 safe;
    logic [CNT_W-1:0]     pending;
    logic                 notify;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_op = '0;
  logic [7:0]  in_msg_type = '0;
  logic [31:0] in_data_handle = '0;
  logic [10:0] in_length = '0;
  logic        in_safe_flag = 1'b0;
  logic [3:0]  in_entry_index = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [3:0]  out_index;
  logic [7:0]  out_type;
  logic [31:0] out_handle;
  logic [10:0] out_length;
  logic        out_safe;
  logic [4:0]  out_pending_count;
  logic        out_priority_notify;

  pooled_message_queue i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_msg_type         (in_msg_type),
    .in_data_handle      (in_data_handle),
    .in_length           (in_length),
    .in_safe_flag        (in_safe_flag),
    .in_entry_index      (in_entry_index),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_index           (out_index),
    .out_type            (out_type),
    .out_handle          (out_handle),
    .out_length          (out_length),
    .out_safe            (out_safe),
    .out_pending_count   (out_pending_count),
    .out_priority_notify (out_priority_notify)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the pool: links, payload, held flags and list pointers.
  logic [PTR_W-1:0]     nxt_link [DEPTH];
  logic [TYPE_BITS-1:0] ent_type [DEPTH];
  logic [HANDLE_W-1:0]  ent_handle [DEPTH];
  logic [LENGTH_W-1:0]  ent_len [DEPTH];
  logic                 ent_safe [DEPTH];
  logic                 is_held [DEPTH];
  logic [PTR_W-1:0]     free_top;
  logic [PTR_W-1:0]     q_head;
  logic [PTR_W-1:0]     q_tail;
  logic [CNT_W-1:0]     q_count;
  logic                 notify_on;

  stim_t  stim_q [$];
  reply_t reply_q [$];

  int words_taken = 0;
  int words_seen = 0;
  int results_checked = 0;
  int full_hits = 0;
  int dup_hits = 0;
  int notify_hits = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  int settle_left = SETTLE_CYCLES;
  int gap_left = 0;
  int gap_hi = 12;
  int n_words = 0;
  bit have_next = 0;
  stim_t nxt_word;

  // Applies one command word to the shadow pool and returns the result word.
  function automatic reply_t predict_reply(logic [2:0] op, logic [TYPE_BITS-1:0] mt,
                                           logic [HANDLE_W-1:0] hd,
                                           logic [LENGTH_W-1:0] ln, logic sf,
                                           logic [IDX_W-1:0] ix);
    reply_t           r;
    logic [PTR_W-1:0] p;
    logic [PTR_W-1:0] prv;
    logic [PTR_W-1:0] nx;
    bit               dup;
    int               g;
    r = '0;
    case (op)
      OP_SEND, OP_SEND_UNQ: begin
        dup = 0;
        if (op == OP_SEND_UNQ) begin
          p = q_head;
          for (g = 0; g < DEPTH && p != NIL; g++) begin
            if (ent_type[p[IDX_W-1:0]] == mt) dup = 1;
            p = nxt_link[p[IDX_W-1:0]];
          end
        end
        if (dup) begin
          r.status = ST_DUP;
        end else if (free_top == NIL) begin
          r.status = ST_FULL;
        end else begin
          p = free_top;
          free_top = nxt_link[p[IDX_W-1:0]];
          ent_type[p[IDX_W-1:0]] = mt;
          ent_handle[p[IDX_W-1:0]] = hd;
          ent_len[p[IDX_W-1:0]] = ln;
          ent_safe[p[IDX_W-1:0]] = sf;
          nxt_link[p[IDX_W-1:0]] = NIL;
          if (q_head != NIL && q_tail != NIL) begin
            nxt_link[q_tail[IDX_W-1:0]] = p;
            q_tail = p;
          end else begin
            q_head = p;
            q_tail = p;
          end
          q_count = q_count + CNT_W'(1);
          r.index = p[IDX_W-1:0];
          r.notify = notify_on;
        end
      end
      OP_RECV, OP_PEEK: begin
        if (q_head == NIL) begin
          r.status = ST_EMPTY;
        end else begin
          p = q_head;
          r.index = p[IDX_W-1:0];
          r.mtype = ent_type[p[IDX_W-1:0]];
          r.handle = ent_handle[p[IDX_W-1:0]];
          r.len = ent_len[p[IDX_W-1:0]];
          r.safe = ent_safe[p[IDX_W-1:0]];
          if (op == OP_RECV) begin
            q_head = nxt_link[p[IDX_W-1:0]];
            if (q_head == NIL) q_tail = NIL;
            nxt_link[p[IDX_W-1:0]] = NIL;
            is_held[p[IDX_W-1:0]] = 1'b1;
            if (q_count != 0) q_count = q_count - CNT_W'(1);
          end
        end
      end
      OP_RELEASE: begin
        if (is_held[ix]) begin
          is_held[ix] = 1'b0;
          nxt_link[ix] = free_top;
          free_top = PTR_W'(ix);
        end else begin
          r.status = ST_EMPTY;
        end
      end
      OP_PURGE: begin
        prv = NIL;
        p = q_head;
        for (g = 0; g < DEPTH && p != NIL; g++) begin
          nx = nxt_link[p[IDX_W-1:0]];
          if (ent_type[p[IDX_W-1:0]] == mt) begin
            if (prv != NIL) nxt_link[prv[IDX_W-1:0]] = nx;
            if (p == q_tail) q_tail = prv;
            if (p == q_head) q_head = nx;
            nxt_link[p[IDX_W-1:0]] = free_top;
            free_top = p;
            if (q_count != 0) q_count = q_count - CNT_W'(1);
          end else begin
            prv = p;
          end
          p = nx;
        end
      end
      OP_FREE_ALL: begin
        p = q_head;
        for (g = 0; g < DEPTH && p != NIL; g++) begin
          nx = nxt_link[p[IDX_W-1:0]];
          nxt_link[p[IDX_W-1:0]] = free_top;
          free_top = p;
          p = nx;
        end
        q_head = NIL;
        q_tail = NIL;
        q_count = '0;
      end
      default: begin
      end
    endcase
    r.pending = q_count;
    return r;
  endfunction

  function automatic void check_field(string nm, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, nm, want, got);
      mismatch_cnt++;
    end
  endfunction

  function automatic void add_word(logic [2:0] op, logic [TYPE_BITS-1:0] mt,
                                   logic [HANDLE_W-1:0] hd, logic [LENGTH_W-1:0] ln,
                                   logic sf, logic [IDX_W-1:0] ix, logic pick);
    stim_t s;
    s = '0;
    s.act = ACT_WORD;
    s.op = op;
    s.mtype = mt;
    s.handle = hd;
    s.len = ln;
    s.safe = sf;
    s.eidx = ix;
    s.pick_held = pick;
    s.gap = (gap_hi == 0) ? 4'd0 : 4'($urandom_range(0, gap_hi));
    stim_q.push_back(s);
    n_words++;
  endfunction

  function automatic void add_rand(logic [2:0] op, logic [TYPE_BITS-1:0] mt, logic pick);
    add_word(op, mt, $urandom, 11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)),
             4'($urandom_range(0, DEPTH - 1)), pick);
  endfunction

  function automatic void add_ctl(act_t act, logic val);
    stim_t s;
    s = '0;
    s.act = act;
    s.cfg_val = val;
    stim_q.push_back(s);
  endfunction

  // A few recurring types make duplicates and purge hits common.
  function automatic logic [TYPE_BITS-1:0] pick_type();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h3C;
      3: return 8'hA5;
      default: return 8'($urandom);
    endcase
  endfunction

  // Prediction and checking, both at the rising edge.
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    int     i;
    if (!rst_n) begin
      for (i = 0; i < DEPTH; i++) begin
        nxt_link[i] = (i + 1 < DEPTH) ? PTR_W'(i + 1) : NIL;
        ent_type[i] = '0;
        ent_handle[i] = '0;
        ent_len[i] = '0;
        ent_safe[i] = 1'b0;
        is_held[i] = 1'b0;
      end
      free_top = '0;
      q_head = NIL;
      q_tail = NIL;
      q_count = '0;
      notify_on = 1'b0;
    end else begin
      if (cfg_we) notify_on = cfg_wdata;
      if (start && !busy) begin
        reply_q.push_back(predict_reply(in_op, in_msg_type, in_data_handle, in_length,
                                        in_safe_flag, in_entry_index));
        words_taken++;
      end
      if (out_valid) begin
        got = {out_status, out_index, out_type, out_handle, out_length, out_safe,
               out_pending_count, out_priority_notify};
        if (reply_q.size() == 0) begin
          $display("%0t: result word with nothing expected, got %0h", $time, got);
          mismatch_cnt++;
        end else begin
          want = reply_q.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("index", 32'(want.index), 32'(got.index));
          check_field("type", 32'(want.mtype), 32'(got.mtype));
          check_field("handle", want.handle, got.handle);
          check_field("length", 32'(want.len), 32'(got.len));
          check_field("safe", 32'(want.safe), 32'(got.safe));
          check_field("pending_count", 32'(want.pending), 32'(got.pending));
          check_field("priority_notify", 32'(want.notify), 32'(got.notify));
          results_checked++;
          if (want.status == ST_FULL) full_hits++;
          if (want.status == ST_DUP) dup_hits++;
          if (want.notify) notify_hits++;
        end
      end
    end
  end

  // Driver: all inputs change at the falling edge.
  always @(negedge clk) begin
    bit go;
    bit we_n;
    int nheld;
    int pick;
    int k;
    stim_t ctl;
    go = 0;
    we_n = 0;
    if (rst_n) begin
      if (start && words_taken == words_seen) begin
        go = 1;
      end else begin
        words_seen = words_taken;
        if (start || reply_q.size() != 0) settle_left = SETTLE_CYCLES;
        else if (settle_left > 0) settle_left--;
        if (!have_next && stim_q.size() != 0 && stim_q[0].act == ACT_WORD) begin
          nxt_word = stim_q.pop_front();
          gap_left = int'(nxt_word.gap);
          have_next = 1;
        end
        if (have_next) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            // Release a word that is really held, when the item asks for it.
            if (nxt_word.pick_held) begin
              nheld = 0;
              for (k = 0; k < DEPTH; k++) if (is_held[k]) nheld++;
              if (nheld != 0) begin
                pick = $urandom_range(0, nheld - 1);
                for (k = 0; k < DEPTH; k++) begin
                  if (is_held[k]) begin
                    if (pick == 0) nxt_word.eidx = IDX_W'(k);
                    pick--;
                  end
                end
              end
            end
            in_op <= nxt_word.op;
            in_msg_type <= nxt_word.mtype;
            in_data_handle <= nxt_word.handle;
            in_length <= nxt_word.len;
            in_safe_flag <= nxt_word.safe;
            in_entry_index <= nxt_word.eidx;
            have_next = 0;
            go = 1;
          end
        end else if (stim_q.size() != 0 && !start && reply_q.size() == 0 &&
                     settle_left == 0) begin
          ctl = stim_q.pop_front();
          if (ctl.act == ACT_CFG) begin
            we_n = 1;
            cfg_wdata <= ctl.cfg_val;
          end
          settle_left = SETTLE_CYCLES;
        end
      end
    end
    start <= go;
    cfg_we <= we_n;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_cnt, reply_q.size());
      $display("pooled_message_queue_tb: errors");
      $finish;
    end
  end

  initial begin
    bit drained;
    int k;
    int seq_len;
    drained = 0;

    // Directed part: empty queue, extremes of the payload, each operation.
    add_ctl(ACT_CFG, 1'b1);
    add_word(OP_PEEK, 8'h00, '0, '0, 1'b0, 4'd0, 1'b0);
    add_word(OP_RECV, 8'h00, '0, '0, 1'b0, 4'd0, 1'b0);
    add_word(OP_RELEASE, 8'h00, '0, '0, 1'b0, 4'd15, 1'b0);
    add_word(OP_SEND, 8'hFF, 32'hFFFF_FFFF, 11'h7FF, 1'b1, 4'd15, 1'b0);
    add_word(OP_SEND, 8'h00, 32'h0, 11'h0, 1'b0, 4'd0, 1'b0);
    add_word(OP_SEND_UNQ, 8'hFF, 32'h1234_5678, 11'h155, 1'b1, 4'd0, 1'b0);
    add_word(OP_SEND_UNQ, 8'h5A, 32'hA5A5_0F0F, 11'h2AA, 1'b0, 4'd0, 1'b0);
    add_word(OP_PEEK, 8'h00, '0, '0, 1'b0, 4'd0, 1'b0);
    add_word(OP_RECV, 8'h00, '0, '0, 1'b0, 4'd0, 1'b0);
    add_word(OP_RELEASE, 8'h00, '0, '0, 1'b0, 4'd0, 1'b0);
    add_word(OP_RELEASE, 8'h00, '0, '0, 1'b0, 4'd0, 1'b0);
    add_word(OP_SEND, 8'h00, 32'h8000_0001, 11'h400, 1'b1, 4'd0, 1'b0);
    add_word(OP_PURGE, 8'h00, '0, '0, 1'b0, 4'd0, 1'b0);
    add_word(OP_PURGE, 8'h77, '0, '0, 1'b0, 4'd0, 1'b0);
    add_word(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 11'h7FF, 1'b1, 4'd15, 1'b0);
    add_word(OP_PEEK, 8'h00, '0, '0, 1'b0, 4'd0, 1'b0);
    add_word(OP_FREE_ALL, 8'h00, '0, '0, 1'b0, 4'd0, 1'b0);
    add_word(OP_FREE_ALL, 8'h00, '0, '0, 1'b0, 4'd0, 1'b0);
    add_word(OP_RECV, 8'h00, '0, '0, 1'b0, 4'd0, 1'b0);
    add_ctl(ACT_CFG, 1'b0);

    // Random part: fill, drain and purge sequences with some plain noise.
    n_words = 0;
    while (n_words < RANDOM_WORDS) begin
      gap_hi = ($urandom_range(0, 3) == 0) ? 0 : 12;
      if ($urandom_range(0, 11) == 0) add_ctl(ACT_CFG, 1'($urandom_range(0, 1)));
      seq_len = $urandom_range(2, 20);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          for (k = 0; k < seq_len; k++)
            add_rand(($urandom_range(0, 3) == 0) ? OP_SEND_UNQ : OP_SEND, pick_type(), 1'b0);
        end
        3, 4, 5: begin
          for (k = 0; k < seq_len / 2 + 1; k++) begin
            add_rand(($urandom_range(0, 3) == 0) ? OP_PEEK : OP_RECV, pick_type(), 1'b0);
            if ($urandom_range(0, 2) != 0) add_rand(OP_RELEASE, pick_type(), 1'b1);
          end
        end
        6: begin
          add_rand(OP_PURGE, pick_type(), 1'b0);
        end
        7: begin
          add_rand(($urandom_range(0, 1) == 0) ? OP_FREE_ALL : OP_PURGE, pick_type(), 1'b0);
        end
        8: begin
          for (k = 0; k < seq_len / 4 + 1; k++) add_rand(OP_RELEASE, pick_type(), 1'b1);
        end
        default: begin
          for (k = 0; k < seq_len / 3 + 1; k++)
            add_rand(3'($urandom_range(0, 7)), 8'($urandom), 1'b0);
        end
      endcase
      if (!drained && n_words > RANDOM_WORDS / 2) begin
        // Let the command stream run dry once before carrying on.
        add_ctl(ACT_DRAIN, 1'b0);
        add_ctl(ACT_CFG, 1'b1);
        drained = 1;
      end
    end
    add_ctl(ACT_CFG, 1'b0);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || have_next || start || reply_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (reply_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, reply_q.size());
      mismatch_cnt++;
    end

    $display("Run covered %0d command words and %0d checked results, %0d mismatches.",
             words_taken, results_checked, mismatch_cnt);
    $display("Pool full %0d times, duplicate drops %0d, notify pulses %0d.",
             full_hits, dup_hits, notify_hits);
    if (mismatch_cnt == 0) begin
      $display("pooled_message_queue_tb: clean");
    end else begin
      $display("pooled_message_queue_tb: errors");
    end
    $finish;
  end

endmodule

// ----- pooled_message_queue.f -----
rtl/pmq_pkg.sv
rtl/pmq_store.sv
rtl/pooled_message_queue.sv
sim/pooled_message_queue_tb.sv
